FILE: hdl/rtqc_pkg.sv
// ----------------------------------------------------------------------------
// Relay transmit queue package
// Shared widths, register indexes, reset values and request/result types.
// ----------------------------------------------------------------------------
package rtqc_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int THR_W       = 6;
  localparam int CMP_W       = (OCC_W > THR_W) ? OCC_W : THR_W;
  localparam int ID_W        = 16;
  localparam int PRI_W       = 3;
  localparam int HDL_W       = 16;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;

  // A non-zero mark means the congestion flag comes out of reset set.
  localparam logic [7:0] JAM_RESET_MARK = 8'hff;

  localparam logic [THR_W-1:0] HIGH_THR_RST   = THR_W'(24);
  localparam logic [THR_W-1:0] LOW_THR_RST    = THR_W'(8);
  localparam logic [ID_W-1:0]  NODE_COUNT_RST = ID_W'(64);
  localparam logic [ID_W-1:0]  OWN_ID_RST     = ID_W'(0);

  localparam logic REQ_RECEIVE = 1'b0;
  localparam logic REQ_CONFIRM = 1'b1;

  typedef enum logic [1:0] {
    REG_HIGH_THR   = 2'd0,
    REG_LOW_THR    = 2'd1,
    REG_NODE_COUNT = 2'd2,
    REG_OWN_ID     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [ID_W-1:0]  dest;
    logic [PRI_W-1:0] pri;
    logic [HDL_W-1:0] handle;
  } desc_t;

  typedef struct packed {
    logic             req_type;
    logic [ID_W-1:0]  pkt_dest;
    logic [PRI_W-1:0] pkt_pri;
    logic [HDL_W-1:0] pkt_handle;
    logic             tx_success;
  } in_item_t;

  typedef struct packed {
    logic             send_valid;
    logic [ID_W-1:0]  send_dest;
    logic [PRI_W-1:0] send_pri;
    logic [HDL_W-1:0] send_handle;
    logic             jam_valid;
    logic             jam_value;
    logic             dropped;
  } out_item_t;

  // Queue operation requested by the control logic for this cycle.
  typedef struct packed {
    logic  push;
    logic  pop;
    desc_t wr_desc;
  } q_ctl_t;

  // Queue status: occupancy before the operation, head descriptor after it.
  typedef struct packed {
    logic [OCC_W-1:0] occupancy;
    desc_t            rd_desc;
  } q_stat_t;

endpackage

FILE: hdl/relay_tx_queue_with_congestion.sv
// An accepted request is held in the input register, then written to the result register.
// Throughput: one request per cycle while the result is not held waiting for out_ready;
// the input and result registers are the two stages, with queue update and send selection between them.
// Reset (rst_n, synchronous, active low): queue empty, block idle, congestion
// flag set, configuration registers at their default values.
// ----------------------------------------------------------------------------
// Relay transmit queue with congestion indication
// Queues received packet descriptors, keeps one packet outstanding and
// reports congestion changes against configurable occupancy thresholds.
// ----------------------------------------------------------------------------
module relay_tx_queue_with_congestion (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  rtqc_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output rtqc_pkg::out_item_t          out_data,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [rtqc_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [rtqc_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [rtqc_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                         cfg_pready
);
  import rtqc_pkg::*;

  logic [THR_W-1:0] high_thr, low_thr;
  logic [ID_W-1:0]  node_count, own_id;

  in_item_t  item_r;
  logic      item_vld_r;
  out_item_t out_r, out_nxt;
  logic      out_vld_r;
  logic      await_r, await_nxt;
  logic      cong_r, cong_nxt;
  logic      fire;

  q_ctl_t  q_ctl;
  q_stat_t q_stat;

  logic [CMP_W-1:0] occ_after;
  logic             do_send;

  rtqc_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .high_thr    (high_thr),
    .low_thr     (low_thr),
    .node_count  (node_count),
    .own_id      (own_id)
  );

  rtqc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (q_ctl),
    .stat  (q_stat)
  );

  assign fire     = item_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !item_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_data;
    end
  end

  always_comb begin
    q_ctl.push    = 1'b0;
    q_ctl.pop     = 1'b0;
    q_ctl.wr_desc = '{dest: item_r.pkt_dest, pri: item_r.pkt_pri,
                      handle: item_r.pkt_handle};
    out_nxt       = '0;
    await_nxt     = await_r;
    cong_nxt      = cong_r;
    do_send       = 1'b0;
    occ_after     = CMP_W'(q_stat.occupancy);

    if (item_r.req_type == REQ_RECEIVE) begin
      q_ctl.push      = fire && (q_stat.occupancy < OCC_W'(QUEUE_DEPTH));
      out_nxt.dropped = (q_stat.occupancy >= OCC_W'(QUEUE_DEPTH));
      if (q_stat.occupancy < OCC_W'(QUEUE_DEPTH)) begin
        occ_after = CMP_W'(q_stat.occupancy) + CMP_W'(1);
      end
      if (!await_r) begin
        if (occ_after != '0) begin
          do_send   = 1'b1;
          await_nxt = 1'b1;
        end
      end else if ((occ_after > CMP_W'(high_thr)) && !cong_r) begin
        out_nxt.jam_valid = 1'b1;
        out_nxt.jam_value = 1'b1;
        cong_nxt          = 1'b1;
      end
    end else if (await_r && item_r.tx_success) begin
      q_ctl.pop = fire && (q_stat.occupancy != '0);
      if (q_stat.occupancy != '0) begin
        occ_after = CMP_W'(q_stat.occupancy) - CMP_W'(1);
      end
      if (occ_after != '0) begin
        do_send = 1'b1;
        if ((occ_after < CMP_W'(low_thr)) && cong_r) begin
          out_nxt.jam_valid = 1'b1;
          out_nxt.jam_value = 1'b0;
          cong_nxt          = 1'b0;
        end
      end else begin
        await_nxt = 1'b0;
      end
    end

    if (do_send) begin
      out_nxt.send_valid  = 1'b1;
      out_nxt.send_dest   = (q_stat.rd_desc.dest > node_count) ? own_id
                                                               : q_stat.rd_desc.dest;
      out_nxt.send_pri    = q_stat.rd_desc.pri;
      out_nxt.send_handle = q_stat.rd_desc.handle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      await_r   <= 1'b0;
      cong_r    <= (JAM_RESET_MARK != '0);
      out_vld_r <= 1'b0;
    end else begin
      if (fire) begin
        await_r <= await_nxt;
        cong_r  <= cong_nxt;
      end
      if (fire) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

FILE: hdl/rtqc_queue.sv
// ----------------------------------------------------------------------------
// Descriptor queue
// Circular descriptor store with head, tail and occupancy registers.
// ----------------------------------------------------------------------------
module rtqc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  rtqc_pkg::q_ctl_t  ctl,
  output rtqc_pkg::q_stat_t stat
);
  import rtqc_pkg::*;

  desc_t            store [QUEUE_DEPTH];
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic [IDX_W-1:0] rd_idx;

  function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + IDX_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      store[tail_r] <= ctl.wr_desc;
    end
  end

  always_comb begin
    head_nxt = ctl.pop  ? wrap_next(head_r) : head_r;
    tail_nxt = ctl.push ? wrap_next(tail_r) : tail_r;
    occ_nxt  = occ_r + OCC_W'(ctl.push) - OCC_W'(ctl.pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      occ_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      occ_r  <= occ_nxt;
    end
  end

  // The head seen after this cycle's operation. A push into an empty queue
  // lands at the head, so its descriptor is forwarded directly.
  assign rd_idx = head_nxt;

  always_comb begin
    stat.occupancy = occ_r;
    if (ctl.push && (occ_r == '0)) begin
      stat.rd_desc = ctl.wr_desc;
    end else begin
      stat.rd_desc = store[rd_idx];
    end
  end

endmodule

FILE: hdl/rtqc_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file for thresholds, node count and local id.
// ----------------------------------------------------------------------------
module rtqc_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [rtqc_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [rtqc_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [rtqc_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                         cfg_pready,
  output logic [rtqc_pkg::THR_W-1:0]   high_thr,
  output logic [rtqc_pkg::THR_W-1:0]   low_thr,
  output logic [rtqc_pkg::ID_W-1:0]    node_count,
  output logic [rtqc_pkg::ID_W-1:0]    own_id
);
  import rtqc_pkg::*;

  logic [THR_W-1:0] high_thr_r, low_thr_r;
  logic [ID_W-1:0]  node_count_r, own_id_r;
  logic             wr_en;
  reg_idx_t         idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign idx        = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_thr_r   <= HIGH_THR_RST;
      low_thr_r    <= LOW_THR_RST;
      node_count_r <= NODE_COUNT_RST;
      own_id_r     <= OWN_ID_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_HIGH_THR:   high_thr_r   <= cfg_pwdata[THR_W-1:0];
        REG_LOW_THR:    low_thr_r    <= cfg_pwdata[THR_W-1:0];
        REG_NODE_COUNT: node_count_r <= cfg_pwdata[ID_W-1:0];
        REG_OWN_ID:     own_id_r     <= cfg_pwdata[ID_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_HIGH_THR:   cfg_prdata = DATA_W'(high_thr_r);
      REG_LOW_THR:    cfg_prdata = DATA_W'(low_thr_r);
      REG_NODE_COUNT: cfg_prdata = DATA_W'(node_count_r);
      REG_OWN_ID:     cfg_prdata = DATA_W'(own_id_r);
      default:        cfg_prdata = '0;
    endcase
  end

  assign high_thr   = high_thr_r;
  assign low_thr    = low_thr_r;
  assign node_count = node_count_r;
  assign own_id     = own_id_r;

endmodule
